// ----- design/esc_pkg.sv -----
// Shared codes and widths for the encoder speed and calibration block.
package esc_pkg;

	typedef enum logic [2:0] {
		MODE_SAMPLE    = 3'd0,
		MODE_RESET     = 3'd1,
		MODE_CAL_START = 3'd2,
		MODE_CAL_STOP  = 3'd3,
		MODE_JUDGE     = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		SIGN_NONE = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} dir_t;

	localparam logic [0:0] REG_COUNTS_PER_REV = 1'd0;
	localparam logic [0:0] REG_MIN_PER_REV    = 1'd1;

	localparam logic [2:0] MULT_NONE = 3'd0;
	localparam logic [2:0] MULT_2X   = 3'd2;
	localparam logic [2:0] MULT_4X   = 3'd4;

	localparam logic [12:0] K_RPM     = 13'd6000;
	localparam logic [12:0] K_PERMILL = 13'd1000;

	localparam logic [15:0] CPR_RESET  = 16'd4096;
	localparam logic [19:0] MIN_RESET  = 20'd100;
	localparam logic [15:0] CPR_FLOOR  = 16'd2;

	localparam int DIV_STEPS = 32;

endpackage

// ----- design/encoder_speed_and_calibration.sv -----
// Encoder speed, running total and calibration with a bit-serial shared divider.
//
//  channel | signals                          | payload
//  --------+----------------------------------+---------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | tuser mode; tdata reading, revs, query
//  output  | m_tvalid m_tready m_tdata         | tdata: totals, speed, calibration, judge
//  config  | cfg_we cfg_index cfg_data        | 0 counts_per_rev, 1 min_per_rev
//
// Sample, calibration stop and judge pass through the restoring divider, which retires
// one quotient bit a cycle; judge runs it twice. Other modes go straight to the output.
// Reset clears all control and calibration state at once; no clearing pass.
// One item is in work at a time; the next is taken while the result waits on m_tready.
module encoder_speed_and_calibration
	import esc_pkg::*;
#(
	parameter int COUNTER_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [19:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// counter_now [15:0], cal_revs_req [31:16], per_rev_query [51:32], zero [55:52]
	input  logic [55:0]  s_tdata,
	// mode [2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// total_count [31:0], last_delta [47:32], speed_rpm [76:48], cal_active [77],
	// cal_total_out [109:78], cal_revs_out [125:110], cal_flips_out [141:126],
	// cal_per_rev_out [173:142], multiplier [176:174], judge_err [207:177]
	output logic [207:0] m_tdata
);

	localparam int CW = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [2:0]      mode_q;
	logic [19:0]     query_q;
	logic            phase_q;

	logic [15:0]     cpr_q;
	logic [19:0]     min_q;

	logic [CW-1:0]   prev_q;
	logic [31:0]     total_q;
	logic [15:0]     delta_q;
	logic [28:0]     rpm_q;
	logic            cal_on_q;
	logic [15:0]     revs_held_q;
	logic [15:0]     flips_q;
	logic [1:0]      sign_q;
	logic [31:0]     lat_total_q;
	logic [15:0]     lat_revs_q;
	logic [15:0]     lat_flips_q;
	logic [31:0]     lat_per_rev_q;
	logic [2:0]      mult_q;
	logic [30:0]     err_q;
	logic [30:0]     e4_q;
	logic [30:0]     mag4_q;

	logic [31:0]     num_q;
	logic [15:0]     rem_q;
	logic [15:0]     den_q;
	logic            neg_q;
	logic [CNT_W-1:0] cnt_q;

	logic            m_tvalid_q;
	logic [207:0]    m_tdata_q;

	logic            accept;
	logic [CW-1:0]   now_c;
	logic [15:0]     delta_c;
	logic [15:0]     revs_c;
	logic [1:0]      dir_c;
	logic [15:0]     eff_cpr;
	logic [15:0]     t_sel;
	logic [20:0]     diff_c;
	logic [15:0]     delta_mag;
	logic [31:0]     total_mag;
	logic [20:0]     mul_mag;
	logic [12:0]     mul_k;
	logic [33:0]     prod_c;
	logic [31:0]     num_c;
	logic [15:0]     den_c;
	logic            neg_c;
	logic [16:0]     trial;
	logic            qbit;
	logic [31:0]     quot_s;
	logic            out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign now_c   = s_tdata[CW-1:0];
	assign delta_c = 16'(now_c) - 16'(prev_q);
	assign revs_c  = s_tdata[31:16];
	assign dir_c   = delta_c[15] ? SIGN_NEG : SIGN_POS;

	assign eff_cpr = (cpr_q < CPR_FLOOR) ? CPR_FLOOR : cpr_q;
	assign t_sel   = phase_q ? {1'b0, eff_cpr[15:1]} : eff_cpr;
	assign diff_c  = {1'b0, query_q} - {5'b0, t_sel};

	assign delta_mag = delta_q[15] ? (16'd0 - delta_q) : delta_q;
	assign total_mag = total_q[31] ? (32'd0 - total_q) : total_q;

	always_comb begin
		mul_mag = 21'd0;
		mul_k   = K_RPM;
		neg_c   = 1'b0;
		den_c   = eff_cpr;
		unique case (mode_q)
			MODE_SAMPLE: begin
				mul_mag = 21'(delta_mag);
				mul_k   = K_RPM;
				neg_c   = delta_q[15];
				den_c   = eff_cpr;
			end
			MODE_JUDGE: begin
				mul_mag = diff_c[20] ? (21'd0 - diff_c) : diff_c;
				mul_k   = K_PERMILL;
				neg_c   = diff_c[20];
				den_c   = t_sel;
			end
			default: begin
				mul_mag = 21'd0;
				mul_k   = K_RPM;
				neg_c   = 1'b0;
				den_c   = revs_held_q;
			end
		endcase
	end

	assign prod_c = 34'(mul_mag) * 34'(mul_k);
	assign num_c  = (mode_q == MODE_CAL_STOP) ? total_mag : prod_c[31:0];

	assign trial  = {rem_q, num_q[31]};
	assign qbit   = (trial >= {1'b0, den_q});
	assign quot_s = neg_q ? (32'd0 - num_q) : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= CPR_RESET;
			min_q <= MIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNTS_PER_REV: cpr_q <= cfg_data[15:0];
				REG_MIN_PER_REV:    min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			num_q <= num_c;
			den_q <= den_c;
			neg_q <= neg_c;
			rem_q <= 16'd0;
		end else if (state_q == ST_DIV) begin
			num_q <= {num_q[30:0], qbit};
			rem_q <= qbit ? 16'(trial - {1'b0, den_q}) : trial[15:0];
		end
		if (accept) begin
			query_q <= s_tdata[51:32];
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {err_q, mult_q, lat_per_rev_q, lat_flips_q, lat_revs_q, lat_total_q,
				cal_on_q, rpm_q, delta_q, total_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= MODE_SAMPLE;
			phase_q       <= 1'b0;
			cnt_q         <= '0;
			prev_q        <= '0;
			total_q       <= '0;
			delta_q       <= '0;
			rpm_q         <= '0;
			cal_on_q      <= 1'b0;
			revs_held_q   <= 16'd1;
			flips_q       <= '0;
			sign_q        <= SIGN_NONE;
			lat_total_q   <= '0;
			lat_revs_q    <= '0;
			lat_flips_q   <= '0;
			lat_per_rev_q <= '0;
			mult_q        <= MULT_NONE;
			err_q         <= '0;
			e4_q          <= '0;
			mag4_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q  <= s_tuser;
						phase_q <= 1'b0;
						mult_q  <= MULT_NONE;
						err_q   <= '0;
						unique case (s_tuser)
							MODE_SAMPLE: begin
								prev_q  <= now_c;
								delta_q <= delta_c;
								total_q <= total_q + {{16{delta_c[15]}}, delta_c};
								if (cal_on_q && delta_c != 16'd0) begin
									if (sign_q != SIGN_NONE && dir_c != sign_q) begin
										flips_q <= flips_q + 16'd1;
									end
									sign_q <= dir_c;
								end
								state_q <= ST_MUL;
							end
							MODE_RESET: begin
								prev_q  <= now_c;
								total_q <= '0;
								delta_q <= '0;
								rpm_q   <= '0;
								state_q <= ST_OUT;
							end
							MODE_CAL_START: begin
								prev_q      <= now_c;
								total_q     <= '0;
								delta_q     <= '0;
								rpm_q       <= '0;
								revs_held_q <= (revs_c == 16'd0) ? 16'd1 : revs_c;
								flips_q     <= '0;
								sign_q      <= SIGN_NONE;
								cal_on_q    <= 1'b1;
								state_q     <= ST_OUT;
							end
							MODE_CAL_STOP: begin
								cal_on_q    <= 1'b0;
								lat_total_q <= total_q;
								lat_revs_q  <= revs_held_q;
								lat_flips_q <= flips_q;
								state_q     <= ST_MUL;
							end
							MODE_JUDGE: begin
								state_q <= ST_MUL;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					unique case (mode_q)
						MODE_SAMPLE: begin
							rpm_q   <= quot_s[28:0];
							state_q <= ST_OUT;
						end
						MODE_CAL_STOP: begin
							lat_per_rev_q <= num_q;
							state_q       <= ST_OUT;
						end
						MODE_JUDGE: begin
							if (!phase_q) begin
								e4_q    <= quot_s[30:0];
								mag4_q  <= num_q[30:0];
								phase_q <= 1'b1;
								state_q <= ST_MUL;
							end else begin
								state_q <= ST_OUT;
								if (query_q < min_q) begin
									mult_q <= MULT_NONE;
									err_q  <= '0;
								end else if (mag4_q <= num_q[30:0]) begin
									mult_q <= MULT_4X;
									err_q  <= e4_q;
								end else begin
									mult_q <= MULT_2X;
									err_q  <= quot_s[30:0];
								end
							end
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
